FILE: hw/rtl/tlr_pkg.sv
package tlr_pkg;

    // Fixed field width of the Q16.16 values
    localparam int unsigned VAL_W = 32;

    // Reset value of the sample interval (1.0 in Q16.16)
    localparam logic [VAL_W-1:0] INTERVAL_RESET = 32'd65536;

    // One input track point
    typedef struct packed {
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_y;
        logic [VAL_W-1:0]        point_time;
        logic                    first_point;
    } point_t;

    // One resampled output item
    typedef struct packed {
        logic signed [VAL_W-1:0] sample_x;
        logic signed [VAL_W-1:0] sample_y;
        logic [VAL_W-1:0]        sample_time;
        logic                    last_of_run;
        logic                    truncated;
    } sample_t;

    // Status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_S0_WAIT,
        ST_COUNT,
        ST_CNT_WAIT,
        ST_SETUP,
        ST_ORIGIN,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT,
        ST_FINISH
    } seq_state_t;

endpackage

FILE: hw/rtl/tlr_divider.sv
module tlr_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [63:0]              dividend,
    input  logic [31:0]              divisor,
    output tlr_pkg::div_status_t     status,
    output logic [31:0]              quotient,
    output logic [31:0]              remainder
);
    import tlr_pkg::*;

    // Restoring divider, one quotient bit per cycle. The upper half of the
    // dividend must already be below the divisor, so the quotient fits 32 bits.
    localparam int unsigned STEPS  = VAL_W;
    localparam int unsigned STEP_W = $clog2(STEPS);

    logic [VAL_W-1:0]  rem_reg;
    logic [VAL_W-1:0]  quo_reg;
    logic [VAL_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [VAL_W:0]    wide;
    logic [VAL_W:0]    trial;
    logic              fits;

    // Trial subtraction of the shifted partial remainder
    always_comb
    begin
        wide  = {rem_reg, quo_reg[VAL_W-1]};
        trial = wide - {1'b0, dsr_reg};
        fits  = (wide >= {1'b0, dsr_reg});
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[2*VAL_W-1:VAL_W];
            quo_reg <= dividend[VAL_W-1:0];
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[VAL_W-1:0] : wide[VAL_W-1:0];
            quo_reg <= {quo_reg[VAL_W-2:0], fits};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

FILE: hw/rtl/track_linear_resampler_top.sv
// Track resampler: takes (x, y, time) points of a track in Q16.16 and emits
// samples at every multiple of sample_interval by linear interpolation on the
// segment that each new point closes. One point is handled at a time, and
// in_stall stays high until it is done. A point that opens a track, repeats
// the previous time or runs backwards is settled in ST_DECIDE and emits no
// sample. A closing point locates and counts its sample times with up to two
// passes of the shared 32-step divider, then emits the zero sample of a new
// track, and then each interpolated sample: x and y each need one pass of the
// multiplier and one pass of the shared divider. A run holds at most
// MAX_PER_SEGMENT samples; a held output stalls the run. Configuration
// writes are always taken.
module track_linear_resampler_top #(
    parameter int unsigned MAX_PER_SEGMENT = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  tlr_pkg::point_t  in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output tlr_pkg::sample_t out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      cfg_data
);
    import tlr_pkg::*;

    localparam int unsigned CW = $clog2(MAX_PER_SEGMENT + 1);
    localparam logic [VAL_W+1:0] MAX_TOTAL = (VAL_W+2)'(MAX_PER_SEGMENT);

    // Sequencer
    seq_state_t state_reg;
    seq_state_t state_next;

    // Architectural state
    logic [VAL_W-1:0] sample_interval_reg;
    logic [VAL_W-1:0] prev_x_reg;
    logic [VAL_W-1:0] prev_y_reg;
    logic [VAL_W-1:0] prev_time_reg;
    logic [VAL_W-1:0] nst_reg;
    logic             have_prev_reg;
    logic             origin_reg;

    // Working registers
    point_t           in_reg;
    logic [VAL_W-1:0] s_reg;
    logic [VAL_W-1:0] end_time_reg;
    logic [VAL_W:0]   cnt_reg;
    logic [CW-1:0]    emit_left_reg;
    logic             trunc_reg;
    logic             axis_reg;
    logic [63:0]      prod_reg;
    logic             neg_reg;
    logic [VAL_W-1:0] x_res_reg;
    logic [VAL_W-1:0] y_res_reg;
    sample_t          out_reg;
    logic             out_valid_reg;

    // Divider connection
    logic             div_start;
    logic [63:0]      div_dividend;
    logic [VAL_W-1:0] div_divisor;
    div_status_t      div_stat;
    logic [VAL_W-1:0] div_quo;
    logic [VAL_W-1:0] div_rem;

    // Combinational helpers
    logic [VAL_W-1:0] iv;
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] span;
    logic             start_trk;
    logic             early;
    logic             same;
    logic             skip_point;
    logic [VAL_W-1:0] round_tgt;
    logic [VAL_W:0]   rounded;
    logic [VAL_W-1:0] rounded_sat;
    logic [VAL_W-1:0] ax_a;
    logic [VAL_W-1:0] ax_b;
    logic [VAL_W:0]   diff;
    logic [VAL_W:0]   mag_w;
    logic [VAL_W-1:0] off;
    logic [63:0]      prod_c;
    logic [VAL_W-1:0] interp_res;
    logic [VAL_W+1:0] total;
    logic [CW-1:0]    n_emit;
    logic             slot_free;
    logic             out_load;
    logic             is_last;

    tlr_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .status    (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Point classification and segment values
    always_comb
    begin
        iv         = (sample_interval_reg == '0) ? VAL_W'(1) : sample_interval_reg;
        base       = origin_reg ? iv : nst_reg;
        span       = in_reg.point_time - prev_time_reg;
        start_trk  = in_reg.first_point || !have_prev_reg;
        early      = (in_reg.point_time < prev_time_reg);
        same       = (in_reg.point_time == prev_time_reg);
        skip_point = start_trk || early || same;
    end

    // Round a target up to the next sample time using the divider remainder
    always_comb
    begin
        round_tgt   = (state_reg == ST_S0_WAIT) ? prev_time_reg : in_reg.point_time;
        rounded     = {1'b0, round_tgt}
                    + {1'b0, ((div_rem != '0) ? (iv - div_rem) : '0)};
        rounded_sat = rounded[VAL_W] ? '1 : rounded[VAL_W-1:0];
    end

    // Interpolation datapath for the current axis
    always_comb
    begin
        ax_a       = axis_reg ? prev_y_reg : prev_x_reg;
        ax_b       = axis_reg ? in_reg.pos_y : in_reg.pos_x;
        diff       = {ax_b[VAL_W-1], ax_b} - {ax_a[VAL_W-1], ax_a};
        mag_w      = diff[VAL_W] ? (~diff + 1'b1) : diff;
        off        = s_reg - prev_time_reg;
        prod_c     = mag_w[VAL_W-1:0] * off;
        interp_res = neg_reg ? (ax_a - div_quo) : (ax_a + div_quo);
    end

    // Run length and output slot
    always_comb
    begin
        total     = {1'b0, cnt_reg} + {{(VAL_W+1){1'b0}}, origin_reg};
        n_emit    = (total > MAX_TOTAL) ? CW'(MAX_PER_SEGMENT) : total[CW-1:0];
        slot_free = !out_valid_reg || !out_stall;
        is_last   = (emit_left_reg == CW'(1));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (skip_point)
                    state_next = ST_IDLE;
                else if (base >= prev_time_reg)
                    state_next = ST_COUNT;
                else
                    state_next = ST_S0_WAIT;
            end
            ST_S0_WAIT:
            begin
                if (div_stat.done)
                    state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                if (s_reg >= in_reg.point_time)
                    state_next = ST_SETUP;
                else
                    state_next = ST_CNT_WAIT;
            end
            ST_CNT_WAIT:
            begin
                if (div_stat.done)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                if (n_emit == '0)
                    state_next = ST_FINISH;
                else if (origin_reg)
                    state_next = ST_ORIGIN;
                else
                    state_next = ST_MUL;
            end
            ST_ORIGIN, ST_EMIT:
            begin
                if (slot_free)
                    state_next = is_last ? ST_FINISH : ST_MUL;
            end
            ST_MUL:
                state_next = ST_DIV_START;
            ST_DIV_START:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                    state_next = axis_reg ? ST_EMIT : ST_MUL;
            end
            ST_FINISH:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall     = (state_reg != ST_IDLE);
        div_start    = 1'b0;
        div_dividend = prod_reg;
        div_divisor  = iv;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_DECIDE:
            begin
                div_start    = !skip_point && (base < prev_time_reg);
                div_dividend = {32'b0, prev_time_reg - base};
            end
            ST_COUNT:
            begin
                div_start    = (s_reg < in_reg.point_time);
                div_dividend = {32'b0, in_reg.point_time - s_reg};
            end
            ST_DIV_START:
            begin
                div_start   = 1'b1;
                div_divisor = span;
            end
            ST_ORIGIN, ST_EMIT:
                out_load = slot_free;
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            sample_interval_reg <= INTERVAL_RESET;
            prev_x_reg          <= '0;
            prev_y_reg          <= '0;
            prev_time_reg       <= '0;
            nst_reg             <= '0;
            have_prev_reg       <= 1'b0;
            origin_reg          <= 1'b1;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
                sample_interval_reg <= cfg_data;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (state_reg == ST_DECIDE)
            begin
                if (start_trk)
                begin
                    prev_x_reg    <= in_reg.pos_x;
                    prev_y_reg    <= in_reg.pos_y;
                    prev_time_reg <= in_reg.point_time;
                    nst_reg       <= '0;
                    have_prev_reg <= 1'b1;
                    origin_reg    <= 1'b1;
                end
                else if (same)
                begin
                    prev_x_reg <= in_reg.pos_x;
                    prev_y_reg <= in_reg.pos_y;
                end
            end

            // Segment closed: the new point becomes the previous one
            if (state_reg == ST_FINISH)
            begin
                prev_x_reg    <= in_reg.pos_x;
                prev_y_reg    <= in_reg.pos_y;
                prev_time_reg <= in_reg.point_time;
                nst_reg       <= end_time_reg;
                origin_reg    <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
            in_reg <= in_data;

        unique case (state_reg)
            ST_DECIDE:
            begin
                if (base >= prev_time_reg)
                    s_reg <= base;
            end
            ST_S0_WAIT:
            begin
                if (div_stat.done)
                    s_reg <= rounded_sat;
            end
            ST_COUNT:
            begin
                cnt_reg      <= '0;
                end_time_reg <= s_reg;
            end
            ST_CNT_WAIT:
            begin
                if (div_stat.done)
                begin
                    cnt_reg      <= {1'b0, div_quo} + {{VAL_W{1'b0}}, (div_rem != '0)};
                    end_time_reg <= rounded_sat;
                end
            end
            ST_SETUP:
            begin
                emit_left_reg <= n_emit;
                trunc_reg     <= (total > MAX_TOTAL);
                axis_reg      <= 1'b0;
            end
            ST_ORIGIN:
            begin
                if (out_load)
                begin
                    out_reg       <= '{sample_x: '0, sample_y: '0, sample_time: '0,
                                       last_of_run: is_last, truncated: trunc_reg};
                    emit_left_reg <= emit_left_reg - 1'b1;
                end
            end
            ST_MUL:
            begin
                prod_reg <= prod_c;
                neg_reg  <= diff[VAL_W];
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (axis_reg)
                        y_res_reg <= interp_res;
                    else
                    begin
                        x_res_reg <= interp_res;
                        axis_reg  <= 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_reg       <= '{sample_x: x_res_reg, sample_y: y_res_reg,
                                       sample_time: s_reg, last_of_run: is_last,
                                       truncated: trunc_reg};
                    emit_left_reg <= emit_left_reg - 1'b1;
                    s_reg         <= s_reg + iv;
                    axis_reg      <= 1'b0;
                end
            end
            default:
            begin
                axis_reg <= axis_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // Checks
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_emit_has_budget: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (emit_left_reg != '0))
        else $error("sample emitted beyond run length");

    a_sample_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (state_reg == ST_EMIT)) |->
            ((s_reg >= prev_time_reg) && (s_reg < in_reg.point_time)))
        else $error("sample time outside segment");

    a_origin_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> !origin_reg)
        else $error("zero sample still pending after segment");

endmodule

FILE: dv/track_linear_resampler_checker.sv
`timescale 1ns / 1ps

module track_linear_resampler_checker
    import tlr_pkg::*;
#(
    parameter int unsigned MAX_PER_SEGMENT = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  point_t     in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  sample_t    out_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [31:0] cfg_data,
    output int         mismatches,
    output int         waiting
);

    // Own copy of the resampler state
    logic [31:0] interval_q;
    logic [31:0] prev_x;
    logic [31:0] prev_y;
    logic [31:0] prev_time;
    logic [31:0] next_time;
    logic        have_prev;
    logic        origin_due;

    // Samples predicted but not yet transferred, oldest first
    sample_t     expected_samples[$];

    // Sample times saturate at the top of the 32-bit range
    function automatic logic [31:0] clamp_time(bit [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // First from + k*step (k >= 0) at or beyond target
    function automatic logic [31:0] advance_to(logic [31:0] from, logic [31:0] target,
                                               logic [31:0] step);
        bit [63:0] gap;
        bit [63:0] k;
        if (from >= target)
            return from;
        gap = 64'(target) - 64'(from);
        k   = (gap + 64'(step) - 64'd1) / 64'(step);
        return clamp_time(64'(from) + k * 64'(step));
    endfunction

    // a + trunc(off * (b - a) / span), product kept exact in 64 bits
    function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b,
                                         logic [31:0] off, logic [31:0] span);
        longint    va;
        longint    diff;
        bit [63:0] mag;
        bit [63:0] q;
        bit [63:0] r;
        va   = longint'(signed'(a));
        diff = longint'(signed'(b)) - va;
        mag  = (diff < 0) ? -diff : diff;
        q    = (mag * 64'(off)) / 64'(span);
        r    = (diff < 0) ? 64'(va) - q : 64'(va) + q;
        return r[31:0];
    endfunction

    // Work out the samples that one accepted point causes
    function automatic void resample_point(point_t p);
        logic [31:0] step;
        logic [31:0] span;
        logic [31:0] off;
        sample_t     run[$];
        sample_t     s;
        bit          clipped;
        step = (interval_q == '0) ? 32'd1 : interval_q;

        // new track: just remember the point
        if (p.first_point || !have_prev) begin
            prev_x     = p.pos_x;
            prev_y     = p.pos_y;
            prev_time  = p.point_time;
            next_time  = '0;
            have_prev  = 1'b1;
            origin_due = 1'b1;
            return;
        end
        // running backwards: dropped
        if (p.point_time < prev_time)
            return;
        // same time: position replaced, nothing emitted
        if (p.point_time == prev_time) begin
            prev_x = p.pos_x;
            prev_y = p.pos_y;
            return;
        end

        span = p.point_time - prev_time;
        if (origin_due) begin
            s = '0;
            run.push_back(s);
            origin_due = 1'b0;
            next_time  = step;
        end
        next_time = advance_to(next_time, prev_time, step);
        while (run.size() < MAX_PER_SEGMENT && next_time < p.point_time) begin
            off           = next_time - prev_time;
            s             = '0;
            s.sample_x    = lerp(prev_x, p.pos_x, off, span);
            s.sample_y    = lerp(prev_y, p.pos_y, off, span);
            s.sample_time = next_time;
            run.push_back(s);
            next_time = clamp_time(64'(next_time) + 64'(step));
        end
        // samples left over in the segment are skipped and flagged
        clipped = next_time < p.point_time;
        if (clipped)
            next_time = advance_to(next_time, p.point_time, step);
        foreach (run[i]) begin
            run[i].truncated   = clipped;
            run[i].last_of_run = (i == run.size() - 1);
            expected_samples.push_back(run[i]);
        end

        prev_x    = p.pos_x;
        prev_y    = p.pos_y;
        prev_time = p.point_time;
    endfunction

    function automatic int check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Watch the three channels; outputs are compared before new points are predicted
    always @(posedge clk or negedge rst_n) begin : track_model
        sample_t want;
        if (!rst_n) begin
            interval_q = INTERVAL_RESET;
            prev_x     = '0;
            prev_y     = '0;
            prev_time  = '0;
            next_time  = '0;
            have_prev  = 1'b0;
            origin_due = 1'b1;
            expected_samples.delete();
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: sample with none due, expected none, got %h",
                             $time, out_data);
                    mismatches++;
                end else begin
                    want = expected_samples.pop_front();
                    mismatches += check_field("sample_x", want.sample_x, out_data.sample_x)
                        + check_field("sample_y", want.sample_y, out_data.sample_y)
                        + check_field("sample_time", want.sample_time,
                                      out_data.sample_time)
                        + check_field("last_of_run", want.last_of_run,
                                      out_data.last_of_run)
                        + check_field("truncated", want.truncated, out_data.truncated);
                end
            end
            if (cfg_valid && cfg_ready)
                interval_q = cfg_data;
            if (in_valid && !in_stall)
                resample_point(in_data);
        end
        waiting = expected_samples.size();
    end

endmodule

FILE: dv/track_linear_resampler_top_tb.sv
`timescale 1ns / 1ps

module track_linear_resampler_top_tb;
    import tlr_pkg::*;

    localparam int unsigned MAX_SAMPLES = 64;
    localparam int          IDLE_LIMIT   = 20000;
    localparam int          QUIET_CYCLES = 300;
    localparam int          HOLD_CYCLES  = 1500;
    localparam int          PHASE_POINTS = 58;
    localparam int          NUM_PHASES   = 8;
    localparam logic [31:0] Q_ONE        = 32'h0001_0000;
    localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN        = 32'h8000_0000;
    localparam logic [31:0] T_END        = 32'hFFFF_FFFF;

    typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    point_t      in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    sample_t     out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    int          fail_count;
    int          samples_due;
    int          idle_cycles  = 0;
    bit          hold_request = 1'b0;

    // Stimulus view of the current track
    logic [31:0] cur_interval = INTERVAL_RESET;
    logic [31:0] track_time   = '0;
    int          track_left   = 0;

    always #5 clk = ~clk;

    track_linear_resampler_top #(
        .MAX_PER_SEGMENT (MAX_SAMPLES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    track_linear_resampler_checker #(
        .MAX_PER_SEGMENT (MAX_SAMPLES)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (fail_count),
        .waiting    (samples_due)
    );

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("track_linear_resampler_top regression: fail");
                $finish;
            end
        end
    end

    // Sample side: stretches of free flow, random stalls, fixed patterns or a long hold
    initial begin : sample_sink
        rx_mode_t mode;
        int       stretch;
        int       stall_k;
        @(posedge rst_n);
        forever begin
            if (hold_request) begin
                // long hold-off so the block backs up onto its input
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end else begin
                mode    = rx_mode_t'($urandom_range(0, 2));
                stretch = $urandom_range(20, 300);
                stall_k = $urandom_range(1, 3);
                for (int c = 0; c < stretch; c++) begin
                    case (mode)
                        RX_FREE:   out_stall <= 1'b0;
                        RX_RANDOM: out_stall <= ($urandom_range(0, 99) < 40);
                        default:   out_stall <= ((c % (stall_k + 2)) < stall_k);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Offer one point and hold it until the transfer
    task automatic drive_point(input point_t p);
        in_data  <= p;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop offering, wait for every due sample, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (samples_due == 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_interval(input logic [31:0] value);
        settle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        cur_interval  = value;
        track_left    = 0;
    endtask

    function automatic point_t make_pt(logic [31:0] x, logic [31:0] y, logic [31:0] t,
                                       logic f);
        point_t p;
        p.pos_x       = x;
        p.pos_y       = y;
        p.point_time  = t;
        p.first_point = f;
        return p;
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 6))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3:    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        point_t      script[$];
        point_t      p;
        logic [31:0] intervals[NUM_PHASES];
        bit   [63:0] step64;
        bit   [63:0] rnd;
        bit   [63:0] reach;
        int          sent;
        int          burst;
        int          roll;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points at the reset interval of 1.0
        script.push_back(make_pt(32'h0005_0000, 32'hFFFD_0000, 32'h0, 1'b0)); // opens, no flag
        script.push_back(make_pt(Q_MAX, Q_MIN, 32'h0002_8000, 1'b0));
        script.push_back(make_pt(Q_MIN, Q_MAX, 32'h0002_8000, 1'b0));        // same time
        script.push_back(make_pt(Q_MAX, Q_MIN, 32'h0004_0000, 1'b0));        // full swing
        script.push_back(make_pt(32'h1, 32'h1, Q_ONE, 1'b0));                // backwards
        script.push_back(make_pt(32'h0, 32'h0, 32'h0004_8000, 1'b0));
        script.push_back(make_pt(32'hFFFF_FFFF, 32'h1, 32'h0004_C000, 1'b0)); // no sample time
        script.push_back(make_pt(32'h0010_0000, Q_MIN, 32'h0064_0000, 1'b0)); // overlong
        script.push_back(make_pt(Q_ONE, 32'h0002_0000, 32'h000A_0000, 1'b1)); // new track
        script.push_back(make_pt(32'hFFFC_0000, 32'h0008_0000, 32'h000C_0000, 1'b0));
        script.push_back(make_pt(Q_MAX, Q_MAX, 32'hFFFF_0000, 1'b1));
        script.push_back(make_pt(Q_MIN, Q_MIN, T_END, 1'b0));                // time saturates
        script.push_back(make_pt(32'h0, Q_MAX, T_END, 1'b0));
        script.push_back(make_pt(32'h0, 32'h0, 32'h0, 1'b1));
        script.push_back(make_pt(32'h3, 32'h3, 32'h0, 1'b0));
        script.push_back(make_pt(32'h7, 32'hFFFF_FFF9, 32'h1, 1'b0));        // zero sample only
        script.push_back(make_pt(32'h0, 32'h0, 32'h0, 1'b1));
        script.push_back(make_pt(Q_MAX, Q_MIN, 32'h0040_0000, 1'b0));        // exactly full run
        script.push_back(make_pt(32'h0, 32'h0, 32'h0, 1'b1));
        script.push_back(make_pt(Q_MIN, Q_MAX, 32'h0040_0001, 1'b0));        // one over
        foreach (script[i]) begin
            drive_point(script[i]);
            if ($urandom_range(0, 2) == 0)
                pause_sender($urandom_range(1, 12));
        end

        intervals[0] = 32'h0;
        intervals[1] = T_END;
        intervals[2] = 32'h1;
        intervals[3] = 32'h0000_4000;
        intervals[4] = 32'h8000_0000;
        intervals[5] = $urandom_range(32'h100, 32'h8_0000);
        intervals[6] = 32'h0003_0000;
        intervals[7] = $urandom_range(1, 32'h40);

        // Random tracks, one interval setting per phase
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_interval(intervals[ph]);
            step64 = (cur_interval == '0) ? 64'd1 : 64'(cur_interval);
            if (ph == 3)
                hold_request = 1'b1;
            sent = 0;
            while (sent < PHASE_POINTS) begin
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                    : $urandom_range(1, 12);
                for (int b = 0; b < burst && sent < PHASE_POINTS; b++) begin
                    roll          = $urandom_range(0, 99);
                    p.pos_x       = pick_coord();
                    p.pos_y       = pick_coord();
                    p.first_point = 1'b0;
                    rnd           = 64'($urandom);
                    if (roll < 5) begin
                        // noise: every field random
                        p.point_time  = $urandom;
                        p.first_point = $urandom_range(0, 1);
                        if (p.first_point) begin
                            track_time = p.point_time;
                            track_left = $urandom_range(2, 8);
                        end else if (p.point_time > track_time) begin
                            track_time = p.point_time;
                        end
                    end else if (track_left == 0) begin
                        // open a track: at zero, near zero or anywhere
                        p.first_point = 1'b1;
                        case ($urandom_range(0, 3))
                            0, 1: p.point_time = '0;
                            2: begin
                                reach = step64 * $urandom_range(0, 20) + rnd % step64;
                                p.point_time = (reach > 64'hFFFF_FFFF) ? T_END : reach[31:0];
                            end
                            default: p.point_time = $urandom;
                        endcase
                        track_time = p.point_time;
                        track_left = $urandom_range(2, 8);
                    end else begin
                        track_left--;
                        if (roll < 12 && track_time != '0) begin
                            p.point_time = $urandom_range(0, track_time - 1);
                        end else if (roll < 20) begin
                            p.point_time = track_time;
                        end else begin
                            // a few segments long enough to be cut off
                            reach = step64 * ((roll < 23) ? $urandom_range(60, 80)
                                                          : $urandom_range(0, 5))
                                    + rnd % step64;
                            if (reach == 0)
                                reach = 64'd1;
                            reach      = 64'(track_time) + reach;
                            track_time = (reach > 64'hFFFF_FFFF) ? T_END : reach[31:0];
                            p.point_time = track_time;
                        end
                    end
                    drive_point(p);
                    sent++;
                end
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 30));
            end
        end

        settle();
        if (fail_count == 0 && samples_due == 0)
            $display("track_linear_resampler_top regression: pass");
        else
            $display("track_linear_resampler_top regression: fail");
        $finish;
    end

endmodule

FILE: track_linear_resampler_top.f
hw/rtl/tlr_pkg.sv
hw/rtl/tlr_divider.sv
hw/rtl/track_linear_resampler_top.sv
dv/track_linear_resampler_checker.sv
dv/track_linear_resampler_top_tb.sv
